// ===== src/scc_pkg.sv =====
// shared types and constants of the sector cache controller
// used by every module of the block; no dependencies
`default_nettype none
package scc_pkg;

  localparam int CACHE_SLOTS  = 4;
  localparam int DEVICE_COUNT = 8;
  localparam int SLOT_W       = 2;
  localparam int DEV_W        = 3;
  localparam int ADDR_W       = 64;
  localparam int CNT_W        = 16;
  localparam int MASK_W       = 8;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CACHE_SLOTS - 1);
  localparam logic [DEV_W:0]    DEV_LIMIT = (DEV_W + 1)'(DEVICE_COUNT);

  localparam int                APB_AW        = 3;
  localparam logic [0:0]        REG_CACHEABLE = 1'b0;

  typedef enum logic [1:0] {
    FN_READ      = 2'd0,
    FN_WRITE     = 2'd1,
    FN_FLUSH_DEV = 2'd2,
    FN_FLUSH_ALL = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    K_DONE = 3'd0,
    K_WB   = 3'd1,
    K_FILL = 3'd2,
    K_PRD  = 3'd3,
    K_PWR  = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_L_RD,
    ST_L_CHK,
    ST_V_RD,
    ST_V_CHK,
    ST_FILL,
    ST_PASS,
    ST_F_RD,
    ST_F_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t              func;
    logic [DEV_W-1:0]   dev;
    logic [ADDR_W-1:0]  addr;
    logic [CNT_W-1:0]   cnt;
    logic [3:0]         wbmask;
    logic               fillf;
    logic               ptf;
  } req_t;

  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [ADDR_W-1:0] addr;
  } tag_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [SLOT_W-1:0] addr;
    tag_t              wr_tag;
  } ram_req_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [DEV_W-1:0]  dev;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt;
    logic              status;
    logic              last;
  } beat_t;

endpackage
`default_nettype wire

// ===== src/sector_cache_controller.sv =====
// one request beat in, one to five result beats out; sequential, one request at a time
// probe reads the tag memory one slot at a time, each in a read state and then a check state
// the next request is accepted once the done beat is loaded and the sequencer is back in idle
// reset clears the slot flags, victim pointer and mask; no clearing pass
// depends on scc_pkg, scc_tag_ram, scc_apb_regs, scc_ctrl
`default_nettype none
module sector_cache_controller
  import scc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  // device_id, block_address, sector_count, writeback_fail_mask, fill_fail,
  // passthrough_fail, zero pad
  input  wire logic [95:0]       s_tdata,
  // func
  input  wire logic [1:0]        s_tuser,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  // slot, target_device, target_address, transfer_count, status, zero pad
  output logic [87:0]            m_tdata,
  // kind
  output logic [2:0]             m_tuser,
  output logic                   m_tlast,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  req_t              in_req;
  beat_t             beat;
  ram_req_t          ram_req;
  tag_t              rd_tag;
  logic [MASK_W-1:0] cacheable_mask;

  assign in_req.func   = func_t'(s_tuser);
  assign in_req.dev    = s_tdata[2:0];
  assign in_req.addr   = s_tdata[66:3];
  assign in_req.cnt    = s_tdata[82:67];
  assign in_req.wbmask = s_tdata[86:83];
  assign in_req.fillf  = s_tdata[87];
  assign in_req.ptf    = s_tdata[88];

  assign m_tdata = {2'b00, beat.status, beat.cnt, beat.addr, beat.dev, beat.slot};
  assign m_tuser = beat.kind;
  assign m_tlast = beat.last;

  scc_apb_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .cacheable_mask (cacheable_mask)
  );

  scc_tag_ram u_tags (
    .clk    (clk),
    .req    (ram_req),
    .rd_tag (rd_tag)
  );

  scc_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_req         (in_req),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_beat       (beat),
    .cacheable_mask (cacheable_mask),
    .ram_req        (ram_req),
    .rd_tag         (rd_tag)
  );

endmodule
`default_nettype wire

// ===== src/scc_tag_ram.sv =====
// tag memory of the cache slots: device and block address per slot
// one write and one registered read per cycle; uses scc_pkg
`default_nettype none
module scc_tag_ram
  import scc_pkg::*;
(
  input  wire logic     clk,
  input  wire ram_req_t req,
  output tag_t          rd_tag
);

  tag_t mem [CACHE_SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_tag;
    end
    if (req.rd_en) begin
      rd_tag <= mem[req.addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/scc_apb_regs.sv =====
// configuration register file: cacheable device mask behind an apb port
// uses scc_pkg
`default_nettype none
module scc_apb_regs
  import scc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  output logic [MASK_W-1:0]      cacheable_mask
);

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready && (paddr[2:2] == REG_CACHEABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cacheable_mask <= '0;
    end else if (wr_hit) begin
      cacheable_mask <= pwdata[MASK_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:2] == REG_CACHEABLE) begin
      prdata = {(32 - MASK_W)'(0), cacheable_mask};
    end
  end

endmodule
`default_nettype wire

// ===== src/scc_ctrl.sv =====
// request sequencer: slot probe, victim allocation, flush walk, pass-through, result register
// holds slot valid and dirty flags and the victim pointer; uses scc_pkg
`default_nettype none
module scc_ctrl
  import scc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire req_t              in_req,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output beat_t                  out_beat,
  input  wire logic [MASK_W-1:0] cacheable_mask,
  output ram_req_t               ram_req,
  input  wire tag_t              rd_tag
);

  state_t state, state_next;

  logic [CACHE_SLOTS-1:0] valid;
  logic [CACHE_SLOTS-1:0] dirty;
  logic [SLOT_W-1:0]      victim;
  logic [SLOT_W-1:0]      idx;
  logic [SLOT_W-1:0]      done_slot;
  logic                   done_status;
  req_t                   req;

  logic  accept, out_free, out_load, dev_known;
  logic  hit, idx_last, need_wb, v_go, sel, f_go, wb_fail, is_wr;
  beat_t beat_next;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign dev_known = {1'b0, in_req.dev} < DEV_LIMIT;

  assign idx_last = (idx == SLOT_LAST);
  assign is_wr    = (req.func == FN_WRITE);
  assign hit      = valid[idx] && (rd_tag.dev == req.dev) && (rd_tag.addr == req.addr);
  assign need_wb  = valid[idx] && dirty[idx];
  assign v_go     = !need_wb || out_free;
  assign sel      = valid[idx] && dirty[idx] &&
                    ((req.func == FN_FLUSH_ALL) || (rd_tag.dev == req.dev));
  assign f_go     = !sel || out_free;
  assign wb_fail  = req.wbmask[idx];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_req.func == FN_FLUSH_DEV || in_req.func == FN_FLUSH_ALL) begin
            if (in_req.func == FN_FLUSH_DEV && !dev_known) state_next = ST_DONE;
            else                                            state_next = ST_F_RD;
          end else if (!dev_known || in_req.cnt == '0) begin
            state_next = ST_DONE;
          end else if (in_req.cnt != CNT_W'(1) || !cacheable_mask[in_req.dev]) begin
            state_next = ST_PASS;
          end else begin
            state_next = ST_L_RD;
          end
        end
      end
      ST_L_RD:  state_next = ST_L_CHK;
      ST_L_CHK: begin
        if (hit)           state_next = ST_DONE;
        else if (idx_last) state_next = ST_V_RD;
        else               state_next = ST_L_RD;
      end
      ST_V_RD:  state_next = ST_V_CHK;
      ST_V_CHK: begin
        if (v_go) state_next = is_wr ? ST_DONE : ST_FILL;
      end
      ST_FILL:  if (out_free) state_next = ST_DONE;
      ST_PASS:  if (out_free) state_next = ST_DONE;
      ST_F_RD:  state_next = ST_F_CHK;
      ST_F_CHK: begin
        if (f_go) state_next = idx_last ? ST_DONE : ST_F_RD;
      end
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_load       = 1'b0;
    beat_next      = '0;
    ram_req        = '0;
    ram_req.addr   = idx;
    ram_req.wr_tag = '{dev: req.dev, addr: req.addr};
    unique case (state)
      ST_L_RD, ST_V_RD, ST_F_RD: ram_req.rd_en = 1'b1;
      ST_V_CHK: begin
        ram_req.wr_en = v_go;
        out_load      = v_go && need_wb;
        beat_next     = '{kind: K_WB, slot: idx, dev: rd_tag.dev, addr: rd_tag.addr,
                          cnt: CNT_W'(1), status: 1'b0, last: 1'b0};
      end
      ST_FILL: begin
        out_load  = out_free;
        beat_next = '{kind: K_FILL, slot: idx, dev: req.dev, addr: req.addr,
                      cnt: CNT_W'(1), status: 1'b0, last: 1'b0};
      end
      ST_PASS: begin
        out_load  = out_free;
        beat_next = '{kind: (req.func == FN_READ) ? K_PRD : K_PWR, slot: '0,
                      dev: req.dev, addr: req.addr, cnt: req.cnt,
                      status: 1'b0, last: 1'b0};
      end
      ST_F_CHK: begin
        out_load  = sel && out_free;
        beat_next = '{kind: K_WB, slot: idx, dev: rd_tag.dev, addr: rd_tag.addr,
                      cnt: CNT_W'(1), status: 1'b0, last: 1'b0};
      end
      ST_DONE: begin
        out_load  = out_free;
        beat_next = '{kind: K_DONE, slot: done_slot, dev: '0, addr: '0, cnt: '0,
                      status: done_status, last: 1'b1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      valid     <= '0;
      dirty     <= '0;
      victim    <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_L_CHK: begin
          if (hit && is_wr) dirty[idx] <= 1'b1;
          if (!hit && idx_last) victim <= (victim == SLOT_LAST) ? '0 : victim + 1'b1;
        end
        ST_V_CHK: begin
          if (v_go) begin
            valid[idx] <= is_wr;
            dirty[idx] <= is_wr;
          end
        end
        ST_FILL: begin
          if (out_free && !req.fillf) valid[idx] <= 1'b1;
        end
        ST_F_CHK: begin
          if (f_go && sel && !wb_fail) dirty[idx] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_beat <= beat_next;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          req         <= in_req;
          idx         <= '0;
          done_slot   <= '0;
          done_status <= !dev_known;
        end
      end
      ST_L_CHK: begin
        if (hit)           done_slot <= idx;
        else if (idx_last) idx       <= victim;
        else               idx       <= idx + 1'b1;
      end
      ST_V_CHK: if (v_go) done_slot <= idx;
      ST_FILL:  if (out_free) done_status <= req.fillf;
      ST_PASS:  if (out_free) done_status <= req.ptf;
      ST_F_CHK: begin
        if (f_go) begin
          if (sel && wb_fail) done_status <= 1'b1;
          if (!idx_last)      idx         <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("request accepted but sequencer stayed idle");

  a_dirty_implies_valid: assert property (@(posedge clk) disable iff (rst)
    (dirty & ~valid) == '0)
    else $error("dirty flag set on an invalid slot");

  a_victim_on_miss: assert property (@(posedge clk) disable iff (rst)
    !$stable(victim) |-> $past(state) == ST_L_CHK)
    else $error("victim pointer moved outside a miss");

endmodule
`default_nettype wire
